// ===== hdl/dnn_pkg.sv =====
// Shared types and constants of the descriptor nearest-neighbor search.
`default_nettype none
package dnn_pkg;

  localparam int MAX_REFS    = 1024;
  localparam int DESC_LEN    = 64;
  localparam int BYTE_W      = 8;
  localparam int DESC_W      = DESC_LEN * BYTE_W;
  localparam int IDX_W       = $clog2(MAX_REFS);
  localparam int CNT_W       = 11;
  localparam int SQ_W        = 2 * BYTE_W;
  localparam int GROUP_LEN   = 8;
  localparam int NGROUPS     = DESC_LEN / GROUP_LEN;
  localparam int GSUM_W      = SQ_W + $clog2(GROUP_LEN);
  localparam int DIST_W      = 22;
  localparam int IN_TDATA_W  = ((IDX_W + DESC_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + DIST_W + 7) / 8) * 8;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_OUT
  } dnn_state_t;

  // Tag that travels with one reference through the compare pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] index;
  } dnn_tag_t;

  // Running minimum seen by the control
  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } dnn_result_t;

endpackage
`default_nettype wire

// ===== hdl/dnn_ref_store.sv =====
// Reference descriptor memory: one write port, one registered read port.
`default_nettype none
module dnn_ref_store (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [dnn_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [dnn_pkg::DESC_W-1:0] wr_data,
  input  wire logic [dnn_pkg::IDX_W-1:0] rd_addr,
  output logic      [dnn_pkg::DESC_W-1:0] rd_data
);
  import dnn_pkg::*;

  logic [DESC_W-1:0] mem [MAX_REFS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/dnn_lane.sv =====
// One byte lane: squared absolute difference, registered.
`default_nettype none
module dnn_lane (
  input  wire logic                       clk,
  input  wire logic [dnn_pkg::BYTE_W-1:0] a,
  input  wire logic [dnn_pkg::BYTE_W-1:0] b,
  output logic      [dnn_pkg::SQ_W-1:0]   sq
);
  import dnn_pkg::*;

  logic [BYTE_W-1:0] diff;

  always_comb begin
    diff = (a >= b) ? (a - b) : (b - a);
  end

  always_ff @(posedge clk) begin
    sq <= SQ_W'(diff) * SQ_W'(diff);
  end

endmodule
`default_nettype wire

// ===== hdl/dnn_merge.sv =====
// Merge stage: registered adder tree over the lanes, then running minimum.
`default_nettype none
module dnn_merge (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dnn_pkg::dnn_tag_t        tag_in,
  input  wire logic [dnn_pkg::SQ_W-1:0] sq [dnn_pkg::DESC_LEN],
  output dnn_pkg::dnn_result_t          res
);
  import dnn_pkg::*;

  logic [GSUM_W-1:0] gsum_next [NGROUPS];
  logic [GSUM_W-1:0] gsum      [NGROUPS];
  logic [DIST_W-1:0] total_next;
  logic [DIST_W-1:0] total;
  dnn_tag_t          tag_s1;
  dnn_tag_t          tag_s2;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_dist;
  logic              done;

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      gsum_next[g] = '0;
      for (int k = 0; k < GROUP_LEN; k++) begin
        gsum_next[g] = gsum_next[g] + GSUM_W'(sq[g * GROUP_LEN + k]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      total_next = total_next + DIST_W'(gsum[g]);
    end
  end

  always_ff @(posedge clk) begin
    gsum  <= gsum_next;
    total <= total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s1 <= '0;
      tag_s2 <= '0;
      done   <= 1'b0;
    end else begin
      tag_s1 <= tag_in;
      tag_s2 <= tag_s1;
      done   <= tag_s2.valid & tag_s2.last;
    end
  end

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (tag_s2.valid && (tag_s2.first || total < best_dist)) begin
      best_dist  <= total;
      best_index <= tag_s2.index;
    end
  end

  assign res.done     = done;
  assign res.index    = best_index;
  assign res.distance = best_dist;

endmodule
`default_nettype wire

// ===== hdl/descriptor_nearest_neighbor.sv =====
// A load writes one reference; a query scans n = min(ref_count, 1024) references before its result.
// Throughput: one reference per cycle through 64 byte lanes; queries run one at a time,
// the memory read port and the lane pipeline being shared by the scan.
// An empty search (ref_count zero) skips the scan and goes straight to the output stage.
// Reset clears control, the count register and the output valid; the reference
// memory holds nothing defined until loaded, and no clearing pass runs.
`default_nettype none
module descriptor_nearest_neighbor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dnn_pkg::CNT_W-1:0]          cfg_wr_data,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // ref_index[9:0], desc_word_0..desc_word_7 [521:10], zero pad [527:522]
  input  wire logic [dnn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type
  input  wire logic                               s_axis_tuser,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // match_index[9:0], min_dist[31:10]
  output logic      [dnn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // no_refs
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast
);
  import dnn_pkg::*;

  dnn_state_t        state;
  dnn_state_t        state_next;
  logic [CNT_W-1:0]  ref_count;
  logic [IDX_W-1:0]  addr;
  logic [IDX_W-1:0]  addr_next;
  logic [IDX_W-1:0]  last_addr;
  logic [DESC_W-1:0] query_desc;
  logic              query_last;
  logic              empty;
  logic              accept;
  logic              is_load;
  logic              is_query;
  logic [CNT_W-1:0]  count_clamped;
  logic              out_load;
  dnn_tag_t          tag0;
  dnn_tag_t          tag1;
  dnn_tag_t          tag2;
  logic [DESC_W-1:0] rd_data;
  logic [SQ_W-1:0]   sq [DESC_LEN];
  dnn_result_t       res;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign is_load       = accept & (s_axis_tuser == REQ_LOAD);
  assign is_query      = accept & (s_axis_tuser == REQ_QUERY);
  assign count_clamped = (ref_count > CNT_W'(MAX_REFS)) ? CNT_W'(MAX_REFS) : ref_count;
  assign out_load      = (state == ST_OUT) & (~m_axis_tvalid | m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
    end else if (cfg_wr_en) begin
      ref_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    unique case (state)
      ST_IDLE: begin
        addr_next = '0;
        if (is_query) begin
          state_next = (ref_count == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_next = addr + 1'b1;
        if (addr == last_addr) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      query_desc <= s_axis_tdata[IDX_W +: DESC_W];
      query_last <= s_axis_tlast;
      empty      <= (ref_count == '0);
      last_addr  <= IDX_W'(count_clamped - 1'b1);
    end
  end

  dnn_ref_store u_store (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (s_axis_tdata[IDX_W-1:0]),
    .wr_data (s_axis_tdata[IDX_W +: DESC_W]),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // tag0 goes with the read address, tag1 with read data, tag2 with lane outputs
  always_comb begin
    tag0.valid = (state == ST_SCAN);
    tag0.first = (addr == '0);
    tag0.last  = (addr == last_addr);
    tag0.index = addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= tag0;
      tag2 <= tag1;
    end
  end

  for (genvar i = 0; i < DESC_LEN; i++) begin : g_lane
    dnn_lane u_lane (
      .clk (clk),
      .a   (query_desc[i * BYTE_W +: BYTE_W]),
      .b   (rd_data[i * BYTE_W +: BYTE_W]),
      .sq  (sq[i])
    );
  end

  dnn_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag2),
    .sq     (sq),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= empty ? '0
                            : OUT_TDATA_W'({res.distance, res.index});
      m_axis_tuser <= empty;
      m_axis_tlast <= query_last;
    end
  end

endmodule
`default_nettype wire
